/* sv/pf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pf_pkg: shared types and constants of the Playfair encryptor
// Command codes, letter constants, the job record that travels from the
// front end to the back end, and the square position helpers.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int unsigned SQ_SIDE  = 5;
  localparam int unsigned SQ_CELLS = 25;
  localparam int unsigned ALPHA    = 26;

  localparam logic [4:0] LETTER_I     = 5'd8;
  localparam logic [4:0] LETTER_J     = 5'd9;
  localparam logic [4:0] LETTER_Z     = 5'd25;
  localparam logic [4:0] FILLER_RESET = 5'd23;
  localparam logic [4:0] CELLS_FULL   = 5'd25;

  localparam logic [6:0] CHAR_A = 7'h41;

  localparam logic [2:0] CMD_START_KEY  = 3'd0;
  localparam logic [2:0] CMD_KEY_LETTER = 3'd1;
  localparam logic [2:0] CMD_FINISH_KEY = 3'd2;
  localparam logic [2:0] CMD_PLAIN      = 3'd3;
  localparam logic [2:0] CMD_END_MSG    = 3'd4;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_PLACE  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_PAIR   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] a;
    logic [4:0] b;
    logic       fin;
  } job_t;

  // Row of a square position 0..24.
  function automatic logic [2:0] sq_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // Column of a square position 0..24.
  function automatic logic [2:0] sq_col(input logic [4:0] p);
    logic [4:0] base;
    logic [4:0] diff;
    base = 5'({2'b00, sq_row(p)} << 2) + {2'b00, sq_row(p)};
    diff = p - base;
    return diff[2:0];
  endfunction

  function automatic logic [4:0] sq_pos(input logic [2:0] r, input logic [2:0] c);
    return 5'({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

endpackage
`default_nettype wire

/* sv/pf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pf_front: command front end
// Accepts commands, folds characters to letter indexes, keeps the open
// digraph and the filler register, and pushes jobs into the queue.
// ----------------------------------------------------------------------------
module pf_front import pf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] ch,
  input  wire logic       filler_letter_we,
  input  wire logic [4:0] filler_letter,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  logic [4:0] filler;
  logic [4:0] pending_letter;
  logic       pending_valid;
  logic [4:0] pending_letter_next;
  logic       pending_valid_next;
  logic       accept;
  logic       is_letter;
  logic [7:0] diff;
  logic [4:0] letter;
  logic [4:0] filler_idx;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    is_letter = 1'b0;
    diff      = ch - 8'h41;
    if (ch >= 8'h61 && ch <= 8'h7a) begin
      is_letter = 1'b1;
      diff      = ch - 8'h61;
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      is_letter = 1'b1;
    end
    letter = (diff[4:0] == LETTER_J) ? LETTER_I : diff[4:0];
  end

  always_comb begin
    if (filler > LETTER_Z) filler_idx = LETTER_Z;
    else if (filler == LETTER_J) filler_idx = LETTER_I;
    else filler_idx = filler;
  end

  always_comb begin
    push                = 1'b0;
    push_job.op         = OP_CLEAR;
    push_job.a          = letter;
    push_job.b          = filler_idx;
    push_job.fin        = 1'b0;
    pending_letter_next = pending_letter;
    pending_valid_next  = pending_valid;
    if (accept) begin
      case (cmd)
        CMD_START_KEY: begin
          push = 1'b1;
        end
        CMD_KEY_LETTER: begin
          push        = is_letter;
          push_job.op = OP_PLACE;
        end
        CMD_FINISH_KEY: begin
          push        = 1'b1;
          push_job.op = OP_FINISH;
        end
        CMD_PLAIN: begin
          if (is_letter) begin
            if (!pending_valid) begin
              pending_letter_next = letter;
              pending_valid_next  = 1'b1;
            end else begin
              push        = 1'b1;
              push_job.op = OP_PAIR;
              push_job.a  = pending_letter;
              if (pending_letter == letter) begin
                // Doubled letter: encipher with the filler, keep it open.
                push_job.b          = filler_idx;
                pending_letter_next = letter;
              end else begin
                push_job.b         = letter;
                pending_valid_next = 1'b0;
              end
            end
          end
        end
        CMD_END_MSG: begin
          if (pending_valid) begin
            push               = 1'b1;
            push_job.op        = OP_PAIR;
            push_job.a         = pending_letter;
            push_job.b         = filler_idx;
            push_job.fin       = 1'b1;
            pending_valid_next = 1'b0;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filler         <= FILLER_RESET;
      pending_letter <= 5'd0;
      pending_valid  <= 1'b0;
    end else begin
      if (filler_letter_we) filler <= filler_letter;
      pending_letter <= pending_letter_next;
      pending_valid  <= pending_valid_next;
    end
  end

endmodule
`default_nettype wire

/* sv/pf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pf_queue: job queue
// A small first-in first-out store of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module pf_queue import pf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output logic      q_full,
  output logic      q_valid,
  output job_t      head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_full  = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

/* sv/pf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pf_back: key square and digraph engine
// Holds the key square, runs key jobs and enciphers digraphs through two
// small memories, and drives the output register.
// ----------------------------------------------------------------------------
module pf_back import pf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  job_t            head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      cipher_char,
  output logic            last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LB   = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_W1   = 3'd3;
  localparam logic [2:0] ST_W2   = 3'd4;
  localparam logic [2:0] ST_FILL = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [4:0]       ks_mem [SQ_CELLS];
  logic [4:0]       lp_mem [ALPHA];
  logic [ALPHA-1:0] used;
  logic [4:0]       fill_count;
  logic [4:0]       fill_idx;
  logic [4:0]       ks_raddr;
  logic [4:0]       ks_rdata;
  logic [4:0]       lp_raddr;
  logic [4:0]       lp_rdata;
  logic [4:0]       b_q;
  logic             used_a;
  logic             used_b;
  logic             fin_q;
  logic [4:0]       p1;
  logic [4:0]       p2;
  logic [4:0]       o1;
  logic [4:0]       o2;
  logic [4:0]       o1_q;
  logic [4:0]       o2_q;
  logic [2:0]       r1, c1, r2, c2;
  logic             out_free;
  logic             place_req;
  logic [4:0]       place_letter;
  logic             place_en;
  logic             clear_en;
  logic [6:0]       sq_char;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && q_valid;
  assign clear_en = pop && (head.op == OP_CLEAR);

  // Placement is shared by single key letters and the finishing walk.
  always_comb begin
    place_req    = 1'b0;
    place_letter = head.a;
    if (pop && head.op == OP_PLACE) begin
      place_req = 1'b1;
    end else if (state == ST_FILL) begin
      place_letter = fill_idx;
      place_req    = (fill_idx != LETTER_J);
    end
  end
  assign place_en = place_req && !used[place_letter] && (fill_count < CELLS_FULL);

  // Digraph position arithmetic.
  always_comb begin
    p2 = used_b ? lp_rdata : 5'd0;
    r1 = sq_row(p1);
    c1 = sq_col(p1);
    r2 = sq_row(p2);
    c2 = sq_col(p2);
    if (r1 == r2) begin
      o1 = sq_pos(r1, wrap_inc(c1));
      o2 = sq_pos(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      o1 = sq_pos(wrap_inc(r1), c1);
      o2 = sq_pos(wrap_inc(r2), c2);
    end else begin
      o1 = sq_pos(r1, c2);
      o2 = sq_pos(r2, c1);
    end
  end

  always_comb begin
    lp_raddr = (state == ST_IDLE) ? head.a : b_q;
    case (state)
      ST_CALC: ks_raddr = o1;
      ST_W1:   ks_raddr = out_free ? o2_q : o1_q;
      default: ks_raddr = o2_q;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          case (head.op)
            OP_PAIR:   state_next = ST_LB;
            OP_FINISH: state_next = ST_FILL;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_LB:   state_next = ST_CALC;
      ST_CALC: state_next = ST_W1;
      ST_W1:   state_next = out_free ? ST_W2 : ST_W1;
      ST_W2:   state_next = out_free ? ST_IDLE : ST_W2;
      ST_FILL: state_next = (fill_idx == LETTER_Z) ? ST_IDLE : ST_FILL;
      default: state_next = ST_IDLE;
    endcase
  end

  // Key square and letter places; positions beyond the fill count read A.
  always_ff @(posedge clk) begin
    if (place_en) begin
      ks_mem[fill_count]   <= place_letter;
      lp_mem[place_letter] <= fill_count;
    end
    ks_rdata <= ks_mem[ks_raddr];
    lp_rdata <= lp_mem[lp_raddr];
  end

  assign sq_char = CHAR_A + {2'b00, ks_rdata};

  always_ff @(posedge clk) begin
    if (pop) begin
      b_q    <= head.b;
      fin_q  <= head.fin;
      used_a <= used[head.a];
      used_b <= used[head.b];
    end
    if (state == ST_LB) p1 <= used_a ? lp_rdata : 5'd0;
    if (state == ST_CALC) begin
      o1_q <= o1;
      o2_q <= o2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      used        <= '0;
      fill_count  <= 5'd0;
      fill_idx    <= 5'd0;
      out_valid   <= 1'b0;
      cipher_char <= CHAR_A;
      last        <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_en) begin
        used       <= '0;
        fill_count <= 5'd0;
      end else if (place_en) begin
        used[place_letter] <= 1'b1;
        fill_count         <= fill_count + 5'd1;
      end
      if (state == ST_FILL) fill_idx <= fill_idx + 5'd1;
      else fill_idx <= 5'd0;
      if (out_free) begin
        out_valid <= 1'b0;
        if (state == ST_W1) begin
          out_valid   <= 1'b1;
          cipher_char <= (o1_q < fill_count) ? sq_char : CHAR_A;
          last        <= 1'b0;
        end else if (state == ST_W2) begin
          out_valid   <= 1'b1;
          cipher_char <= (o2_q < fill_count) ? sq_char : CHAR_A;
          last        <= fin_q;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/playfair_cipher_encrypt_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// The first cipher letter of a pair is registered out of ST_W1, after the job has passed
// the queue and the states ST_IDLE, ST_LB and ST_CALC; the second comes out of ST_W2.
// A digraph holds the back end from ST_IDLE through ST_W2 (two lookups in each of the two
// memories, one after the other); key letters and start key are done as they are popped,
// finish key holds it in ST_FILL while it walks the alphabet. Plain letters that
// open a pair cost the back end nothing. Reset is synchronous and active high: it empties
// the square, drops any open letter, empties the job queue and sets the filler to X.
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt_core: streaming Playfair encryptor
// The front end turns each command into a job for the key square engine and
// keeps the open digraph. A job queue decouples it from the back end, which
// builds the key square and enciphers letter pairs into the output register.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt_core import pf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Command channel: a transfer happens when in_valid is high and in_stall low.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] ch,
  // Filler register write port.
  input  wire logic       filler_letter_we,
  input  wire logic [4:0] filler_letter,
  // Cipher channel: a transfer happens when out_valid is high and out_stall low.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      cipher_char,
  output logic            last
);

  // Jobs flow front -> queue -> back in command order, so key updates and
  // enciphering never overtake each other.
  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  pf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .ch               (ch),
    .filler_letter_we (filler_letter_we),
    .filler_letter    (filler_letter),
    .q_full           (q_full),
    .push             (push),
    .push_job         (push_job)
  );

  // The queue lets the front end keep accepting letters while the back end
  // is busy with a digraph or a stalled output.
  pf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  pf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_char (cipher_char),
    .last        (last)
  );

endmodule
`default_nettype wire
